// File: hdl/ring_neighbor_grant_arbiter_macros.svh
// Assertion macros shared by the ring neighbor grant arbiter checkers.
// Needs nothing else; each macro expands to one labeled concurrent assertion.
`ifndef RING_NEIGHBOR_GRANT_ARBITER_MACROS_SVH
`define RING_NEIGHBOR_GRANT_ARBITER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define RNGA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ring arbiter check failed");

// Next-cycle implication, disabled while reset is high.
`define RNGA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ring arbiter check failed");

`endif

// File: hdl/rnga_pkg.sv
// Package for the ring neighbor grant arbiter: field widths, reset values
// and request/status codes. Depends on nothing.
package rnga_pkg;

   localparam int SEATS_DEF  = 10;
   localparam int SEAT_W     = 4;
   localparam int CNT_W      = 4;
   localparam int MASK_W     = 10;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 24;

   localparam logic [CNT_W-1:0] LIMIT_RST = 4'd3;

   typedef enum logic {
      ACT_REQUEST = 1'b0,
      ACT_RELEASE = 1'b1
   } action_type;

   typedef enum logic {
      STATUS_OK      = 1'b0,
      STATUS_IGNORED = 1'b1
   } status_type;

endpackage

// File: hdl/ring_neighbor_grant_arbiter.sv
// Ring neighbor grant arbiter: seats on a ring ask to eat and release; a seat
// is granted when neither neighbor eats and its meal count is below the limit.
// A request goes through the input register, then the result register, to
// rsp. Throughput: one request per cycle; the stages stall only while a
// result waits on rsp_tready.
// Reset (synchronous): all seats thinking, meal counts zero, meal limit 3.
// Depends on rnga_pkg.
module ring_neighbor_grant_arbiter
   import rnga_pkg::*;
#(
   parameter int SEATS = SEATS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [3:0] seat, [7:4] zero
   input  logic                  req_tuser,   // [0] action
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [9:0] grant_mask, [19:10] eating_mask,
                                              // [20] status, [23:21] zero
   input  logic                  csr_wr_en,
   input  logic [CNT_W-1:0]      csr_wr_data  // meal_limit
);

   localparam int  CW   = ($clog2(SEATS) > SEAT_W) ? $clog2(SEATS) : SEAT_W;
   localparam bit  TRIO = (SEATS == 3);

   logic                  in_vld_ff;
   action_type            in_act_ff;
   logic [SEAT_W-1:0]     in_seat_ff;
   logic                  out_vld_ff;
   logic [RSP_DATA_W-1:0] out_data_ff, out_data_in;
   logic [CNT_W-1:0]      limit_ff;
   logic [SEATS-1:0]      eat_ff, eat_in, hungry_ff, hungry_in;
   logic [CNT_W-1:0]      cnt_ff [SEATS];
   logic [CNT_W-1:0]      cnt_in [SEATS];

   logic             advance, fire;
   logic [CW-1:0]    seat_x;
   logic [SEATS-1:0] sel_s, sel_l, sel_r, eat_lft, eat_rgt, grant_vec;
   logic [CNT_W-1:0] cnt_s;
   logic             s_eat, s_hun, s_think, s_nbr_eat;
   logic             l_hun, l_far_eat, r_hun, r_far_eat, limit_nz;
   logic             do_req, do_rel, grant_s, grant_l, grant_r;
   logic [MASK_W-1:0] grant_m, eat_m;
   status_type       status;

   assign advance    = !out_vld_ff || rsp_tready;
   assign fire       = in_vld_ff && advance;
   assign req_tready = !in_vld_ff || advance;
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;
   assign seat_x     = CW'(in_seat_ff);

   // Decode the acting seat and its two ring neighbors as one-hot vectors, and pick the seat's meal count.
   always_comb begin
      for (int i = 0; i < SEATS; i++) begin
         sel_s[i]   = (seat_x == CW'(i));
         eat_lft[i] = eat_ff[(i + SEATS - 1) % SEATS];
         eat_rgt[i] = eat_ff[(i + 1) % SEATS];
      end
      for (int i = 0; i < SEATS; i++) begin
         sel_l[i] = sel_s[(i + 1) % SEATS];
         sel_r[i] = sel_s[(i + SEATS - 1) % SEATS];
      end
      cnt_s = '0;
      for (int i = 0; i < SEATS; i++) begin
         if (sel_s[i]) begin
            cnt_s = cnt_s | cnt_ff[i];
         end
      end
   end

   assign s_eat     = |(eat_ff & sel_s);
   assign s_hun     = |(hungry_ff & sel_s);
   assign s_think   = (|sel_s) && !s_eat && !s_hun;
   assign s_nbr_eat = |((eat_lft | eat_rgt) & sel_s);
   assign l_hun     = |(hungry_ff & sel_l);
   assign l_far_eat = |(eat_lft & sel_l);
   assign r_hun     = |(hungry_ff & sel_r);
   assign r_far_eat = |(eat_rgt & sel_r);
   assign limit_nz  = (limit_ff != '0);

   assign do_req  = (in_act_ff == ACT_REQUEST) && s_think;
   assign do_rel  = (in_act_ff == ACT_RELEASE) && s_eat;
   assign grant_s = do_req && !s_nbr_eat && (cnt_s < limit_ff);
   // Neighbor counts are cleared by the release, so only a zero limit blocks them.
   assign grant_l = do_rel && l_hun && !l_far_eat && limit_nz;
   // On a ring of three the right neighbor's far side is the left neighbor.
   assign grant_r = do_rel && r_hun && !(r_far_eat || (TRIO && grant_l)) && limit_nz;

   assign grant_vec = (sel_s & {SEATS{grant_s}}) | (sel_l & {SEATS{grant_l}})
                    | (sel_r & {SEATS{grant_r}});
   assign eat_in    = (eat_ff & ~(sel_s & {SEATS{do_rel}})) | grant_vec;
   assign hungry_in = (hungry_ff | (sel_s & {SEATS{do_req}})) & ~grant_vec;

   always_comb begin
      for (int i = 0; i < SEATS; i++) begin
         cnt_in[i] = cnt_ff[i];
         if (do_rel && (sel_l[i] || sel_r[i])) begin
            cnt_in[i] = '0;
         end
         if (grant_vec[i]) begin
            cnt_in[i] = cnt_in[i] + CNT_W'(1);
         end
      end
   end

   for (genvar m = 0; m < MASK_W; m++) begin : g_mask
      if (m < SEATS) begin : g_seat
         assign grant_m[m] = grant_vec[m];
         assign eat_m[m]   = eat_in[m];
      end else begin : g_none
         assign grant_m[m] = 1'b0;
         assign eat_m[m]   = 1'b0;
      end
   end

   assign status      = (do_req || do_rel) ? STATUS_OK : STATUS_IGNORED;
   assign out_data_in = {(RSP_DATA_W - 2 * MASK_W - 1)'(0), status, eat_m, grant_m};

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         limit_ff   <= LIMIT_RST;
         eat_ff     <= '0;
         hungry_ff  <= '0;
         for (int i = 0; i < SEATS; i++) begin
            cnt_ff[i] <= '0;
         end
      end else begin
         if (req_tready) begin
            in_vld_ff <= req_tvalid;
         end
         if (advance) begin
            out_vld_ff <= in_vld_ff;
         end
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
         if (fire) begin
            eat_ff    <= eat_in;
            hungry_ff <= hungry_in;
            for (int i = 0; i < SEATS; i++) begin
               cnt_ff[i] <= cnt_in[i];
            end
         end
      end
   end

   // Payload registers: load on acceptance or fire, no reset needed.
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_act_ff  <= action_type'(req_tuser);
         in_seat_ff <= req_tdata[SEAT_W-1:0];
      end
      if (fire) begin
         out_data_ff <= out_data_in;
      end
   end

endmodule

// File: hdl/rnga_checker.sv
// Port-level checks for the ring neighbor grant arbiter, bound to the top level.
// Depends on rnga_pkg and ring_neighbor_grant_arbiter_macros.svh.
`include "ring_neighbor_grant_arbiter_macros.svh"

module rnga_checker
   import rnga_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata    // [9:0] grant_mask, [19:10] eating_mask,
                                             // [20] status, [23:21] zero
);

   logic [MASK_W-1:0] grant_m, eat_m;
   logic              ignored;

   assign grant_m = rsp_tdata[MASK_W-1:0];
   assign eat_m   = rsp_tdata[2*MASK_W-1:MASK_W];
   assign ignored = (rsp_tdata[2*MASK_W] == STATUS_IGNORED);

   // A fresh grant must show up as eating in the same result.
   `RNGA_ASSERT_NOW(a_grant_eats, clock, reset, rsp_tvalid, (grant_m & ~eat_m) == '0)
   // Adjacent seats never eat together (the wrap from the last seat to seat 0 is not checked).
   `RNGA_ASSERT_NOW(a_no_adjacent, clock, reset, rsp_tvalid, (eat_m & (eat_m >> 1)) == '0)
   // An ignored request grants nothing.
   `RNGA_ASSERT_NOW(a_ignored_quiet, clock, reset, rsp_tvalid && ignored, grant_m == '0)
   // Hold a stalled result.
   `RNGA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

endmodule

bind ring_neighbor_grant_arbiter rnga_checker u_rnga_checker (.*);
